### sv/bfa_pkg.sv
`timescale 1ns / 1ps
// bfa_pkg: shared types and constants of the bitmap frame allocator.
// No dependencies; bfa_word_eval, bfa_ctrl and the top level import it.

package bfa_pkg;

    localparam int unsigned FRAME_W    = 18;     // frame index plus headroom for run ends
    localparam int unsigned COUNT_W    = 17;     // frame count and range registers
    localparam int unsigned GRANT_W    = 16;     // start frame reported back
    localparam int unsigned IDX_W      = 7;      // bit position inside a word, 0..64
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned FRAME_SPAN = 2 ** 17; // frames any request can ever touch

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_MARK  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_START = 2'd0,
        CFG_RANGE_LIMIT = 2'd1
    } cfg_index_t;

    localparam count_t RANGE_START_RST = 17'h00000;
    localparam count_t RANGE_LIMIT_RST = 17'h10000;

    typedef struct packed {
        kind_t               kind;
        logic [GRANT_W-1:0]  first_frame;
        count_t              frame_total;
    } cmd_t;

    typedef struct packed {
        logic [GRANT_W-1:0]  granted_frame;
        logic                status;
    } res_t;

    // Summary of one map word, produced by the word evaluator.
    typedef struct packed {
        logic              vld;
        frame_t            base;     // frame index of bit 0
        logic              any_set;  // some bit blocked
        logic [IDX_W-1:0]  tz;       // clear bits below the lowest blocked bit
        logic [IDX_W-1:0]  hs;       // highest blocked bit
        logic              int_ok;   // a whole run fits inside the word
        logic [IDX_W-1:0]  int_pos;  // lowest start of such a run
    } word_feat_t;

endpackage

### sv/bfa_req_if.sv
`timescale 1ns / 1ps
// bfa_req_if: request channel of the frame allocator (valid/ready plus payload).
// Depends on nothing.

interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] first_frame;
    logic [16:0] frame_total;

    modport source (output valid, output kind, output first_frame, output frame_total,
                    input ready);
    modport sink   (input valid, input kind, input first_frame, input frame_total,
                    output ready);
endinterface

### sv/bfa_rsp_if.sv
`timescale 1ns / 1ps
// bfa_rsp_if: response channel of the frame allocator (valid/ready plus payload).
// Depends on nothing.

interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_frame;
    logic        status;

    modport source (output valid, output granted_frame, output status, input ready);
    modport sink   (input valid, input granted_frame, input status, output ready);
endinterface

### sv/bfa_word_eval.sv
`timescale 1ns / 1ps
// bfa_word_eval: shared word unit. Builds the in-range mask of one map word and
// registers its run summary (blocked bits, edge runs, inner run). Uses bfa_pkg.

module bfa_word_eval #(
    parameter int unsigned MAP_WORD_BITS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic [MAP_WORD_BITS-1:0] word,
    input  bfa_pkg::frame_t          base,
    input  bfa_pkg::frame_t          lo,
    input  bfa_pkg::frame_t          hi,
    input  bfa_pkg::count_t          total,
    output logic [MAP_WORD_BITS-1:0] in_range,
    output bfa_pkg::word_feat_t      feat
);
    import bfa_pkg::*;

    localparam int unsigned W   = MAP_WORD_BITS;
    localparam int unsigned LW  = $clog2(W);
    localparam frame_t      W_F = frame_t'(W);

    typedef logic [W-1:0] word_t;

    word_t      lo_mask;
    word_t      hi_mask;
    word_t      blk;
    word_t      acc;
    word_feat_t feat_next;
    word_feat_t feat_reg;

    // Frames in [lo, hi) are in range.
    always_comb
    begin
        frame_t lo_off;
        frame_t hi_off;
        lo_off = lo - base;
        hi_off = hi - base;
        if (lo <= base)
            lo_mask = '1;
        else if (lo_off >= W_F)
            lo_mask = '0;
        else
            lo_mask = word_t'('1) << lo_off[LW-1:0];
        if (hi <= base)
            hi_mask = '0;
        else if (hi_off >= W_F)
            hi_mask = '1;
        else
            hi_mask = ~(word_t'('1) << hi_off[LW-1:0]);
        in_range = lo_mask & hi_mask;
        blk      = word | ~in_range;
    end

    // Inner run: z[k] marks starts of 2**k clear bits; the set bits of total
    // pick segments laid end to end.
    always_comb
    begin
        word_t z [LW];
        z[0] = ~blk;
        for (int k = 1; k < LW; k++)
            z[k] = z[k-1] & (z[k-1] >> (1 << (k - 1)));
        acc = '1;
        for (int k = 0; k < LW; k++)
            if (total[k])
                acc = acc & (z[k] >> (total[LW-1:0] & LW'((1 << k) - 1)));
    end

    always_comb
    begin
        feat_next.vld     = in_vld;
        feat_next.base    = base;
        feat_next.any_set = |blk;
        feat_next.tz      = IDX_W'(W);
        for (int j = W - 1; j >= 0; j--)
            if (blk[j])
                feat_next.tz = IDX_W'(j);
        feat_next.hs = '0;
        for (int j = 0; j < W; j++)
            if (blk[j])
                feat_next.hs = IDX_W'(j);
        feat_next.int_ok = (total != '0) && (total < count_t'(W)) && (acc != '0);
        feat_next.int_pos = '0;
        for (int j = W - 1; j >= 0; j--)
            if (acc[j])
                feat_next.int_pos = IDX_W'(j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            feat_reg <= '0;
        else
            feat_reg <= feat_next;
    end

    assign feat = feat_reg;

endmodule

### sv/bfa_ctrl.sv
`timescale 1ns / 1ps
// bfa_ctrl: sequencer and usage map memory. Runs the clearing pass, the first-fit
// scan and the read-modify-write pass. Uses bfa_pkg and bfa_word_eval.

module bfa_ctrl #(
    parameter int unsigned FRAME_COUNT   = 65536,
    parameter int unsigned MAP_WORD_BITS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  bfa_pkg::cmd_t   cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output bfa_pkg::res_t   res,
    input  bfa_pkg::count_t range_start,
    input  bfa_pkg::count_t range_limit
);
    import bfa_pkg::*;

    localparam int unsigned W      = MAP_WORD_BITS;
    localparam int unsigned DEPTH  = (FRAME_COUNT + W - 1) / W;
    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam frame_t      W_F    = frame_t'(W);
    localparam frame_t      FC_CLIP =
        frame_t'((FRAME_COUNT > FRAME_SPAN) ? FRAME_SPAN : FRAME_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef logic [W-1:0] word_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    frame_t               rd_base_reg, rd_base_next;
    logic                 s1_vld_reg, s1_vld_next;
    logic [AW-1:0]        s1_addr_reg;
    frame_t               s1_base_reg;
    logic [AW-1:0]        s2_addr_reg;
    frame_t               lo_reg, lo_next;
    frame_t               hi_reg, hi_next;
    count_t               total_reg, total_next;
    logic                 set_reg, set_next;
    frame_t               run_start_reg, run_start_next;
    frame_t               run_len_reg, run_len_next;
    logic [AW-1:0]        rs_addr_reg, rs_addr_next;
    frame_t               rs_base_reg, rs_base_next;
    res_t                 res_reg, res_next;

    word_t                map_mem [DEPTH];
    word_t                mem_q;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    word_t                mem_wdata;
    logic                 rd_go;

    word_t                in_range;
    word_feat_t           feat;

    bfa_word_eval #(
        .MAP_WORD_BITS(MAP_WORD_BITS)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s1_vld_reg && (state_reg == ST_SCAN)),
        .word     (mem_q),
        .base     (s1_base_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .total    (total_reg),
        .in_range (in_range),
        .feat     (feat)
    );

    assign rd_go = ((state_reg == ST_SCAN) || (state_reg == ST_WRITE)) && (rd_base_reg < hi_reg);

    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_WRITE) && s1_vld_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? rd_addr_reg : s1_addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 :
                       set_reg ? (mem_q | in_range) : (mem_q & ~in_range);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (rd_go)
            mem_q <= map_mem[rd_addr_reg];
    end

    always_comb
    begin
        frame_t lo_a;
        frame_t hi_a;
        frame_t w_end;
        frame_t w_hi;
        frame_t run_sum;
        frame_t win;
        logic [FRAME_W:0] word_end;

        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        rd_base_next   = rd_base_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        total_next     = total_reg;
        set_next       = set_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        rs_addr_next   = rs_addr_reg;
        rs_base_next   = rs_base_reg;
        res_next       = res_reg;

        lo_a     = frame_t'(range_start);
        hi_a     = (frame_t'(range_limit) > FC_CLIP) ? FC_CLIP : frame_t'(range_limit);
        w_end    = frame_t'(cmd.first_frame) + frame_t'(cmd.frame_total);
        w_hi     = (w_end > FC_CLIP) ? FC_CLIP : w_end;
        run_sum  = run_len_reg + frame_t'(feat.tz);
        win      = feat.base + frame_t'(feat.int_pos);
        word_end = {1'b0, feat.base} + {1'b0, W_F};

        if (rd_go)
        begin
            rd_addr_next = rd_addr_reg + AW'(1);
            rd_base_next = rd_base_reg + W_F;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                rd_addr_next = rd_addr_reg + AW'(1);
                if (rd_addr_reg == LAST_ADDR)
                begin
                    rd_addr_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    total_next   = cmd.frame_total;
                    rd_addr_next = '0;
                    rd_base_next = '0;
                    res_next     = '0;
                    unique case (cmd.kind)
                        KIND_ALLOC:
                        begin
                            if (cmd.frame_total == '0)
                            begin
                                res_next.granted_frame = range_start[GRANT_W-1:0];
                                state_next = ST_RESP;
                            end
                            else if (lo_a >= hi_a)
                            begin
                                res_next.status = 1'b1;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                lo_next        = lo_a;
                                hi_next        = hi_a;
                                run_start_next = lo_a;
                                run_len_next   = '0;
                                rs_addr_next   = '0;
                                rs_base_next   = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        KIND_FREE, KIND_MARK:
                        begin
                            lo_next  = frame_t'(cmd.first_frame);
                            hi_next  = w_hi;
                            set_next = (cmd.kind == KIND_MARK);
                            if (w_hi <= frame_t'(cmd.first_frame))
                                state_next = ST_RESP;
                            else
                                state_next = ST_WRITE;
                        end
                        default:
                            state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (feat.vld)
                begin
                    priority if (run_sum >= frame_t'(total_reg))
                    begin
                        // run carried in from earlier words completes here
                        lo_next      = run_start_reg;
                        hi_next      = run_start_reg + frame_t'(total_reg);
                        rd_addr_next = rs_addr_reg;
                        rd_base_next = rs_base_reg;
                        set_next     = 1'b1;
                        res_next.granted_frame = run_start_reg[GRANT_W-1:0];
                        state_next   = ST_WRITE;
                    end
                    else if (feat.int_ok)
                    begin
                        lo_next      = win;
                        hi_next      = win + frame_t'(total_reg);
                        rd_addr_next = s2_addr_reg;
                        rd_base_next = feat.base;
                        set_next     = 1'b1;
                        res_next.granted_frame = win[GRANT_W-1:0];
                        state_next   = ST_WRITE;
                    end
                    else if (word_end >= {1'b0, hi_reg})
                    begin
                        res_next.status = 1'b1;
                        state_next      = ST_RESP;
                    end
                    else if (feat.any_set)
                    begin
                        run_start_next = feat.base + frame_t'(feat.hs) + frame_t'(1);
                        run_len_next   = W_F - frame_t'(feat.hs) - frame_t'(1);
                        rs_addr_next   = s2_addr_reg;
                        rs_base_next   = feat.base;
                    end
                    else
                    begin
                        run_len_next = run_len_reg + W_F;
                    end
                end
            end
            ST_WRITE:
            begin
                if (s1_vld_reg && (({1'b0, s1_base_reg} + {1'b0, W_F}) >= {1'b0, hi_reg}))
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        s1_vld_next = rd_go && (state_next == state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rd_addr_reg   <= '0;
            rd_base_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            s1_addr_reg   <= '0;
            s1_base_reg   <= '0;
            s2_addr_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            total_reg     <= '0;
            set_reg       <= 1'b0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            rs_addr_reg   <= '0;
            rs_base_reg   <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            rd_base_reg   <= rd_base_next;
            s1_vld_reg    <= s1_vld_next;
            s1_addr_reg   <= rd_addr_reg;
            s1_base_reg   <= rd_base_reg;
            s2_addr_reg   <= s1_addr_reg;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            total_reg     <= total_next;
            set_reg       <= set_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            rs_addr_reg   <= rs_addr_next;
            rs_base_reg   <= rs_base_next;
            res_reg       <= res_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

endmodule

### sv/bitmap_frame_allocator_top.sv
`timescale 1ns / 1ps
// bitmap_frame_allocator_top: first-fit bitmap page frame allocator, top level.
// Depends on bfa_pkg, bfa_req_if, bfa_rsp_if and bfa_ctrl.
//
// Usage:
//   req  : valid/ready request channel (kind, first_frame, frame_total).
//          kind 0 allocates frame_total contiguous frames, 1 frees a run,
//          2 marks a run allocated. One transaction is in service at a time.
//   rsp  : valid/ready response channel, one transaction per request
//          (granted_frame, status; status 1 = no contiguous run found).
//   cfg  : cfg_wr_en/cfg_index/cfg_data write port for range_start (index 0)
//          and range_limit (index 1). Write only while the block is idle.
// Timing:
//   The usage map sits in a single-port-write, single-port-read memory of
//   FRAME_COUNT/MAP_WORD_BITS words; one word is read per cycle.
//   An allocate scans from word 0 up to the word holding the search limit
//   (stopping early on a hit), then rewrites the granted run at one word per
//   cycle. Free and mark walk from word 0 to the end of the run. A zero-count
//   allocate, an unused kind or an empty run answers without a map pass.
// Reset:
//   After rst_n releases, a clearing pass writes every map word to zero,
//   with req.ready low. Config writes are taken throughout.
// Back-pressure:
//   The response sits in an output register; the sequencer may finish its
//   next transaction and then waits while rsp.ready stays low.

module bitmap_frame_allocator_top #(
    parameter int unsigned FRAME_COUNT   = 65536,
    parameter int unsigned MAP_WORD_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bfa_req_if.sink                       req,
    bfa_rsp_if.source                     rsp,
    input  logic                          cfg_wr_en,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  bfa_pkg::count_t               cfg_data
);
    import bfa_pkg::*;

    count_t range_start_reg;
    count_t range_limit_reg;

    cmd_t   cmd;
    logic   cmd_ready;
    res_t   res;
    logic   res_valid;
    logic   res_ready;

    logic   out_vld_reg;
    res_t   out_res_reg;

    // Configuration registers; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= RANGE_START_RST;
            range_limit_reg <= RANGE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RANGE_START: range_start_reg <= cfg_data;
                CFG_RANGE_LIMIT: range_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cmd.kind        = kind_t'(req.kind);
    assign cmd.first_frame = req.first_frame;
    assign cmd.frame_total = req.frame_total;
    assign req.ready       = cmd_ready;

    bfa_ctrl #(
        .FRAME_COUNT   (FRAME_COUNT),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (req.valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .range_start (range_start_reg),
        .range_limit (range_limit_reg)
    );

    // Output register: loads when empty or being drained.
    assign res_ready = !out_vld_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            out_res_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_vld_reg <= 1'b1;
            out_res_reg <= res;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.granted_frame = out_res_reg.granted_frame;
    assign rsp.status        = out_res_reg.status;

endmodule

### sv/bfa_checker.sv
`timescale 1ns / 1ps
// bfa_checker: port-level assertions for the frame allocator and its bind.
// Depends on bitmap_frame_allocator_top, bfa_req_if and bfa_rsp_if.

module bfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] granted_frame,
    input logic        status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(granted_frame) && $stable(status))
        else $error("response payload changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> granted_frame == 16'h0000)
        else $error("failed allocation reports a nonzero frame");

    a_one_in_service: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in service");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .granted_frame (rsp.granted_frame),
    .status        (rsp.status)
);
